>>> hdl/k_way_merge_multikey_core_macros.svh
// Assertion helpers shared by the merge core modules
`ifndef K_WAY_MERGE_MULTIKEY_CORE_MACROS_SVH
`define K_WAY_MERGE_MULTIKEY_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define KWM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define KWM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/kwm_pkg.sv
`timescale 1ns / 1ps
package kwm_pkg;

  localparam int unsigned DefRuns     = 16;
  localparam int unsigned DefRunDepth = 64;
  localparam int unsigned NumCols     = 4;
  localparam int unsigned ColW        = 32;
  localparam int unsigned MaxSlot     = 64;

  typedef logic [NumCols-1:0][ColW-1:0] row_t;

  typedef enum logic [1:0] {
    ST_ROW    = 2'd0,
    ST_PUSHED = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_DROP   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CFG_KEY_COUNT = 3'd0,
    CFG_KEY0_COL  = 3'd1,
    CFG_KEY0_DESC = 3'd2,
    CFG_KEY1_COL  = 3'd3,
    CFG_KEY1_DESC = 3'd4,
    CFG_KEY2_COL  = 3'd5,
    CFG_KEY2_DESC = 3'd6,
    CFG_ROWS_PAGE = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_SCAN,
    S_LAST,
    S_COMMIT
  } state_e;

  typedef struct packed {
    logic               op;
    logic [3:0]         run;
    logic signed [31:0] col0;
    logic signed [31:0] col1;
    logic signed [31:0] col2;
    logic signed [31:0] col3;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic [3:0]         source_run;
    logic signed [31:0] out_col0;
    logic signed [31:0] out_col1;
    logic signed [31:0] out_col2;
    logic signed [31:0] out_col3;
    logic [15:0]        page_number;
    logic [6:0]         row_slot;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic take;    // input ready
    logic start;   // clear scan state on accept
    logic push;    // perform push, load output
    logic issue;   // issue head read for scan run
    logic cmp;     // compare head returned from memory
    logic commit;  // pop winner, load output
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_valid;
    logic in_op;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

>>> hdl/kwm_if.sv
`timescale 1ns / 1ps
interface kwm_in_if;
  import kwm_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kwm_out_if;
  import kwm_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/kwm_ram.sv
`timescale 1ns / 1ps
module kwm_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/kwm_ctrl.sv
`timescale 1ns / 1ps
`include "k_way_merge_multikey_core_macros.svh"
module kwm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  kwm_pkg::sts_t sts_i,
  output kwm_pkg::cmd_t cmd_o
);
  import kwm_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign accept = (state_q == S_IDLE) && sts_i.in_valid;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.take  = 1'b1;
        cmd_o.start = sts_i.in_valid;
        if (sts_i.in_valid) begin
          state_d = sts_i.in_op ? S_SCAN : S_PUSH;
        end
      end
      S_PUSH: begin
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd_o.issue = 1'b1;
        cmd_o.cmp   = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        cmd_o.cmp = 1'b1;
        state_d   = S_COMMIT;
      end
      S_COMMIT: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  `KWM_ASSERT_NEXT(a_accept_busy, accept, state_q != S_IDLE, "accepted beat left controller idle")
  `KWM_ASSERT_NEXT(a_scan_end, (state_q == S_SCAN) && sts_i.scan_last, state_q == S_LAST,
                   "scan did not drain after last run")
  `KWM_ASSERT_NEXT(a_last_commit, state_q == S_LAST, state_q == S_COMMIT,
                   "drain cycle not followed by commit")

endmodule

>>> hdl/kwm_dp.sv
`timescale 1ns / 1ps
`include "k_way_merge_multikey_core_macros.svh"
module kwm_dp #(
  parameter int unsigned RUNS      = kwm_pkg::DefRuns,
  parameter int unsigned RUN_DEPTH = kwm_pkg::DefRunDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [6:0]    cfg_data_i,
  kwm_in_if.sink        in_if,
  kwm_out_if.source     out_if,
  input  kwm_pkg::cmd_t cmd_i,
  output kwm_pkg::sts_t sts_o
);
  import kwm_pkg::*;

  localparam int unsigned RW    = $clog2(RUNS);
  localparam int unsigned PW    = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
  localparam int unsigned CW    = $clog2(RUN_DEPTH + 1);
  localparam int unsigned Depth = RUNS * RUN_DEPTH;
  localparam int unsigned AW    = $clog2(Depth);

  // configuration
  logic [1:0] key_count_q;
  logic [1:0] key_col_q [3];
  logic       key_desc_q [3];
  logic [6:0] rows_page_q;

  // item and run bookkeeping
  in_item_t        item_q;
  logic [PW-1:0]   ptr_q [RUNS];
  logic [CW-1:0]   cnt_q [RUNS];
  logic [15:0]     page_q;
  logic [6:0]      slot_q;

  // scan state
  logic [RW-1:0]   scan_q;
  logic            cand_v_q;
  logic [RW-1:0]   cand_run_q;
  logic            found_q;
  logic [RW-1:0]   best_run_q;
  row_t            best_row_q;

  // output register
  logic            out_v_q;
  out_item_t       out_q;
  out_item_t       out_d;

  logic [RW-1:0]   idx;
  logic [PW-1:0]   ptr_sel;
  logic [CW-1:0]   cnt_sel;
  logic            run_oob;
  logic            drop;
  logic [CW:0]     pos_sum;
  logic [PW-1:0]   pos;
  logic [PW-1:0]   ptr_inc;
  logic            mem_we;
  logic [AW-1:0]   waddr;
  logic [AW-1:0]   raddr;
  row_t            wrow;
  row_t            rrow;
  logic            prec;
  logic [1:0]      kc;
  logic [6:0]      rpp;
  logic            wrap;
  logic [15:0]     page_nx;
  logic [6:0]      slot_nx;
  logic            out_free;

  // handshake and status
  assign in_if.ready   = cmd_i.take;
  assign out_if.valid  = out_v_q;
  assign out_if.data   = out_q;
  assign out_free      = !out_v_q || out_if.ready;
  assign sts_o.in_valid  = in_if.valid;
  assign sts_o.in_op     = in_if.data.op;
  assign sts_o.scan_last = (scan_q == RW'(RUNS - 1));
  assign sts_o.out_free  = out_free;

  // run table port: push run, winner on commit, scan run otherwise
  always_comb begin
    if (cmd_i.push) begin
      idx = RW'(item_q.run);
    end else if (cmd_i.commit) begin
      idx = best_run_q;
    end else begin
      idx = scan_q;
    end
  end
  assign ptr_sel = ptr_q[idx];
  assign cnt_sel = cnt_q[idx];

  // push address: tail slot of the run's ring
  assign run_oob = 32'(item_q.run) >= RUNS;
  assign drop    = run_oob || (cnt_sel == CW'(RUN_DEPTH));
  assign pos_sum = (CW+1)'(ptr_sel) + (CW+1)'(cnt_sel);
  assign pos     = (pos_sum >= (CW+1)'(RUN_DEPTH)) ? PW'(pos_sum - (CW+1)'(RUN_DEPTH))
                                                   : PW'(pos_sum);
  assign ptr_inc = (ptr_sel == PW'(RUN_DEPTH - 1)) ? '0 : ptr_sel + PW'(1);
  assign mem_we  = cmd_i.push && !drop;
  assign waddr   = AW'(idx) * AW'(RUN_DEPTH) + AW'(pos);
  assign raddr   = AW'(scan_q) * AW'(RUN_DEPTH) + AW'(ptr_sel);
  assign wrow    = {item_q.col3, item_q.col2, item_q.col1, item_q.col0};

  kwm_ram #(
    .WIDTH (NumCols * ColW),
    .DEPTH (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr),
    .wdata_i (wrow),
    .raddr_i (raddr),
    .rdata_o (rrow)
  );

  // multikey order: candidate strictly before current best
  assign kc = (key_count_q == 2'd0) ? 2'd1 : key_count_q;
  always_comb begin
    logic done;
    logic [ColW-1:0] va, vb;
    done = 1'b0;
    prec = 1'b0;
    for (int k = 0; k < 3; k++) begin
      va = rrow[key_col_q[k]];
      vb = best_row_q[key_col_q[k]];
      if (!done && (k < int'(kc)) && (va != vb)) begin
        done = 1'b1;
        prec = key_desc_q[k] ? ($signed(va) > $signed(vb)) : ($signed(va) < $signed(vb));
      end
    end
  end

  // page and slot tagging
  assign rpp     = (rows_page_q == 7'd0) ? 7'd1 :
                   (rows_page_q > 7'(MaxSlot)) ? 7'(MaxSlot) : rows_page_q;
  assign wrap    = slot_q > rpp;
  assign page_nx = wrap ? page_q + 16'd1 : page_q;
  assign slot_nx = wrap ? 7'd1 : slot_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q   <= 2'd1;
      key_col_q[0]  <= 2'd0;
      key_col_q[1]  <= 2'd1;
      key_col_q[2]  <= 2'd2;
      key_desc_q[0] <= 1'b0;
      key_desc_q[1] <= 1'b0;
      key_desc_q[2] <= 1'b0;
      rows_page_q   <= 7'd64;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_KEY_COUNT: key_count_q   <= cfg_data_i[1:0];
        CFG_KEY0_COL:  key_col_q[0]  <= cfg_data_i[1:0];
        CFG_KEY0_DESC: key_desc_q[0] <= cfg_data_i[0];
        CFG_KEY1_COL:  key_col_q[1]  <= cfg_data_i[1:0];
        CFG_KEY1_DESC: key_desc_q[1] <= cfg_data_i[0];
        CFG_KEY2_COL:  key_col_q[2]  <= cfg_data_i[1:0];
        CFG_KEY2_DESC: key_desc_q[2] <= cfg_data_i[0];
        CFG_ROWS_PAGE: rows_page_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && in_if.valid) begin
      item_q <= in_if.data;
    end
  end

  // run pointers, counters, scan control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < int'(RUNS); r++) begin
        ptr_q[r] <= '0;
        cnt_q[r] <= '0;
      end
      page_q     <= '0;
      slot_q     <= 7'd1;
      scan_q     <= '0;
      cand_v_q   <= 1'b0;
      cand_run_q <= '0;
      found_q    <= 1'b0;
      best_run_q <= '0;
    end else begin
      if (cmd_i.start) begin
        scan_q   <= '0;
        cand_v_q <= 1'b0;
        found_q  <= 1'b0;
      end
      if (cmd_i.cmp && cand_v_q && (!found_q || prec)) begin
        found_q    <= 1'b1;
        best_run_q <= cand_run_q;
      end
      if (cmd_i.issue) begin
        cand_v_q   <= cnt_sel != '0;
        cand_run_q <= scan_q;
        scan_q     <= scan_q + RW'(1);
      end else if (cmd_i.cmp) begin
        cand_v_q <= 1'b0;
      end
      if (mem_we) begin
        cnt_q[idx] <= cnt_sel + CW'(1);
      end
      if (cmd_i.commit && found_q) begin
        ptr_q[idx] <= ptr_inc;
        cnt_q[idx] <= cnt_sel - CW'(1);
        page_q     <= page_nx;
        slot_q     <= slot_nx + 7'd1;
      end
    end
  end

  // winning row payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp && cand_v_q && (!found_q || prec)) begin
      best_row_q <= rrow;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (cmd_i.push || cmd_i.commit) begin
      out_v_q <= 1'b1;
    end else if (out_if.ready) begin
      out_v_q <= 1'b0;
    end
  end

  // result payload, zero fields unless a row is delivered
  always_comb begin
    out_d = '0;
    if (cmd_i.push) begin
      out_d.status = drop ? ST_DROP : ST_PUSHED;
    end else if (found_q) begin
      out_d.status      = ST_ROW;
      out_d.source_run  = 4'(best_run_q);
      out_d.out_col0    = best_row_q[0];
      out_d.out_col1    = best_row_q[1];
      out_d.out_col2    = best_row_q[2];
      out_d.out_col3    = best_row_q[3];
      out_d.page_number = page_nx;
      out_d.row_slot    = slot_nx;
    end else begin
      out_d.status = ST_EMPTY;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push || cmd_i.commit) begin
      out_q <= out_d;
    end
  end

  `KWM_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_sel <= CW'(RUN_DEPTH), "run fill count above depth")
  `KWM_ASSERT_NOW(a_win_nonempty, cmd_i.commit && found_q, cnt_sel != '0,
                  "winning run is empty at commit")
  `KWM_ASSERT_NOW(a_load_free, cmd_i.push || cmd_i.commit, out_free,
                  "result loaded over a beat not yet taken")

endmodule

>>> hdl/k_way_merge_multikey_core.sv
`timescale 1ns / 1ps
// k-way merge of sorted runs under a configurable multi-key row order.
// in_if: one beat per item. op 0 pushes row col0..col3 onto run 'run';
//   op 1 pops the best head row over all non-empty runs.
// out_if: one beat per item with status (row, pushed, empty, dropped),
//   the row, its source run, page number and slot within the page.
// cfg_*: write enable, register index and data; write only while idle.
// Sequence: a push goes through PUSH, where it loads the output register; a pop
//   goes through SCAN, LAST and COMMIT. The scan reads one run head per cycle from the
//   row memory and compares it with the current best; COMMIT pops the winner
//   and loads the output register.
// One item is in work at a time; the output register lets the next item be
//   accepted while a finished beat waits. If the receiver stalls, the next
//   result waits in its final step until the output register frees.
// Reset (rst_ni low, asynchronous): all runs empty, page 0, slot 1,
//   registers to defaults. No memory clearing pass is needed.
module k_way_merge_multikey_core #(
  parameter int unsigned RUNS      = kwm_pkg::DefRuns,
  parameter int unsigned RUN_DEPTH = kwm_pkg::DefRunDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [6:0] cfg_data_i,
  kwm_in_if.sink     in_if,
  kwm_out_if.source  out_if
);
  import kwm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  kwm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  kwm_dp #(
    .RUNS      (RUNS),
    .RUN_DEPTH (RUN_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_if),
    .out_if     (out_if),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule

>>> verif/k_way_merge_multikey_core_tb.sv
`timescale 1ns / 1ps
module k_way_merge_multikey_core_tb;
  import kwm_pkg::*;

  localparam int unsigned NRuns      = DefRuns;
  localparam int unsigned Depth      = DefRunDepth;
  localparam int          CycleLimit = 400000;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [6:0] cfg_data_i;

  kwm_in_if  in_if ();
  kwm_out_if out_if ();

  k_way_merge_multikey_core dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_if     (in_if.sink),
    .out_if    (out_if.source)
  );

  // shadow of the run queues and registers
  row_t        run_rows [NRuns][$];
  logic [15:0] page_cnt;
  logic [6:0]  slot_cnt;
  logic [1:0]  key_cnt;
  logic [1:0]  key_col [3];
  logic        key_desc [3];
  logic [6:0]  rows_page;

  out_item_t merged_q [$];
  int        errors;
  int        cycles;
  int        send_idle_pct;
  int        recv_stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // true if row a goes strictly ahead of row b
  function automatic bit row_ahead(row_t a, row_t b);
    int n;
    logic [31:0] va, vb;
    n = (key_cnt == 0) ? 1 : key_cnt;
    for (int k = 0; k < n; k++) begin
      va = a[key_col[k]] ^ 32'h8000_0000;
      vb = b[key_col[k]] ^ 32'h8000_0000;
      if (va != vb) return key_desc[k] ? (va > vb) : (va < vb);
    end
    return 1'b0;
  endfunction

  function automatic out_item_t merge_step(in_item_t it);
    out_item_t res;
    row_t new_row;
    int best;
    int rpp;
    res = '0;
    if (it.op == 1'b0) begin
      if (run_rows[it.run].size() >= Depth) begin
        res.status = ST_DROP;
      end else begin
        new_row = {it.col3, it.col2, it.col1, it.col0};
        run_rows[it.run] = {run_rows[it.run], new_row};
        res.status = ST_PUSHED;
      end
      return res;
    end
    best = -1;
    for (int r = 0; r < NRuns; r++) begin
      if (run_rows[r].size() == 0) continue;
      if (best < 0 || row_ahead(run_rows[r][0], run_rows[best][0])) best = r;
    end
    if (best < 0) begin
      res.status = ST_EMPTY;
      return res;
    end
    rpp = (rows_page == 0) ? 1 : (rows_page > MaxSlot ? MaxSlot : rows_page);
    if (slot_cnt > rpp) begin
      page_cnt = page_cnt + 16'd1;
      slot_cnt = 7'd1;
    end
    res.status      = ST_ROW;
    res.source_run  = best[3:0];
    res.out_col0    = run_rows[best][0][0];
    res.out_col1    = run_rows[best][0][1];
    res.out_col2    = run_rows[best][0][2];
    res.out_col3    = run_rows[best][0][3];
    res.page_number = page_cnt;
    res.row_slot    = slot_cnt;
    void'(run_rows[best].pop_front());
    slot_cnt = slot_cnt + 7'd1;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
  endtask

  // result monitor and receiver stalls
  always @(posedge clk_i) begin
    out_item_t e;
    out_item_t g;
    if (rst_ni && out_if.valid && out_if.ready) begin
      g = out_if.data;
      if (merged_q.size() == 0) begin
        report_mismatch("unexpected beat", g.status, 0);
      end else begin
        e = merged_q.pop_front();
        if (g.status != e.status) report_mismatch("status", g.status, e.status);
        if (g.source_run != e.source_run)
          report_mismatch("source_run", g.source_run, e.source_run);
        if (g.out_col0 != e.out_col0) report_mismatch("out_col0", g.out_col0, e.out_col0);
        if (g.out_col1 != e.out_col1) report_mismatch("out_col1", g.out_col1, e.out_col1);
        if (g.out_col2 != e.out_col2) report_mismatch("out_col2", g.out_col2, e.out_col2);
        if (g.out_col3 != e.out_col3) report_mismatch("out_col3", g.out_col3, e.out_col3);
        if (g.page_number != e.page_number)
          report_mismatch("page_number", g.page_number, e.page_number);
        if (g.row_slot != e.row_slot) report_mismatch("row_slot", g.row_slot, e.row_slot);
      end
    end
  end

  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [6:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_KEY_COUNT: key_cnt = val[1:0];
      CFG_KEY0_COL:  key_col[0] = val[1:0];
      CFG_KEY0_DESC: key_desc[0] = val[0];
      CFG_KEY1_COL:  key_col[1] = val[1:0];
      CFG_KEY1_DESC: key_desc[1] = val[0];
      CFG_KEY2_COL:  key_col[2] = val[1:0];
      CFG_KEY2_DESC: key_desc[2] = val[0];
      CFG_ROWS_PAGE: rows_page = val;
      default: ;
    endcase
  endtask

  // drive one item; the beat is taken at the next edge with ready high
  task automatic send_item(in_item_t it);
    out_item_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    want = merge_step(it);
    merged_q = {merged_q, want};
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_drain();
    in_if.valid <= 1'b0;
    while (merged_q.size() != 0) @(negedge clk_i);
    repeat (NRuns + 8) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_col();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t rand_push(int max_run);
    in_item_t it;
    it.op   = 1'b0;
    it.run  = 4'($urandom_range(max_run));
    it.col0 = rand_col();
    it.col1 = rand_col();
    it.col2 = rand_col();
    it.col3 = rand_col();
    return it;
  endfunction

  // directed stimulus: op, run, columns, expected status (-1: predictor only)
  typedef struct {
    logic        op;
    logic [3:0]  run;
    logic [31:0] c0, c1, c2, c3;
    int          want;
  } dir_row_t;

  dir_row_t dir_tab [] = '{
    '{1'b1, 4'd0,  32'd0, 32'd0, 32'd0, 32'd0, ST_EMPTY},
    '{1'b0, 4'd0,  32'h8000_0000, 32'h7fff_ffff, 32'd0, 32'hffff_ffff, ST_PUSHED},
    '{1'b0, 4'd15, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'd0, ST_PUSHED},
    '{1'b0, 4'd3,  32'h8000_0000, 32'd5, 32'd1, 32'd2, ST_PUSHED},
    '{1'b0, 4'd7,  32'hffff_ffff, 32'd9, 32'd9, 32'd9, ST_PUSHED},
    '{1'b1, 4'd0,  32'd0, 32'd0, 32'd0, 32'd0, -1},
    '{1'b1, 4'd0,  32'd0, 32'd0, 32'd0, 32'd0, -1},
    '{1'b1, 4'd15, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, -1},
    '{1'b1, 4'd0,  32'd0, 32'd0, 32'd0, 32'd0, -1},
    '{1'b1, 4'd0,  32'd0, 32'd0, 32'd0, 32'd0, ST_EMPTY}
  };

  initial begin
    in_item_t it;
    int n_items;
    int pcts[4][2] = '{'{0, 0}, '{79, 0}, '{0, 79}, '{24, 24}};
    errors = 0; cycles = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    rst_ni = 1'b0; cfg_we_i = 1'b0; cfg_idx_i = CFG_KEY_COUNT; cfg_data_i = '0;
    in_if.valid = 1'b0; in_if.data = '0; out_if.ready = 1'b0;
    page_cnt = '0; slot_cnt = 7'd1; key_cnt = 2'd1;
    key_col = '{2'd0, 2'd1, 2'd2}; key_desc = '{1'b0, 1'b0, 1'b0};
    rows_page = 7'd64;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table, default order
    foreach (dir_tab[i]) begin
      it = '{dir_tab[i].op, dir_tab[i].run, dir_tab[i].c0, dir_tab[i].c1,
             dir_tab[i].c2, dir_tab[i].c3};
      send_item(it);
      if (dir_tab[i].want >= 0 && merged_q[$].status != status_e'(dir_tab[i].want))
        report_mismatch("table status", merged_q[$].status, dir_tab[i].want);
    end
    wait_drain();
    // full run: fill run 2 then one more push is dropped, then empty it
    write_reg(CFG_ROWS_PAGE, 7'd1);
    for (int i = 0; i <= Depth; i++) begin
      it = rand_push(0);
      it.run = 4'd2;
      send_item(it);
    end
    wait_drain();
    for (int i = 0; i <= Depth; i++) begin
      it = '0; it.op = 1'b1; send_item(it);
    end
    wait_drain();

    // random phases over register settings and idling mixes
    n_items = 0;
    for (int ph = 0; ph < 8; ph++) begin
      send_idle_pct  = pcts[ph % 4][0];
      recv_stall_pct = pcts[ph % 4][1];
      write_reg(CFG_KEY_COUNT, (ph == 0) ? 7'd0 : (ph == 1) ? 7'd3 :
                               7'($urandom_range(3)));
      write_reg(CFG_KEY0_COL,  7'($urandom_range(3)));
      write_reg(CFG_KEY0_DESC, 7'(ph[0]));
      write_reg(CFG_KEY1_COL,  7'($urandom_range(3)));
      write_reg(CFG_KEY1_DESC, 7'(ph[1]));
      write_reg(CFG_KEY2_COL,  7'($urandom_range(3)));
      write_reg(CFG_KEY2_DESC, 7'(ph[2]));
      write_reg(CFG_ROWS_PAGE, (ph == 2) ? 7'd0 : (ph == 3) ? 7'd127 :
                               (ph == 4) ? 7'd64 : 7'($urandom_range(1, 8)));
      for (int i = 0; i < 40; i++) begin
        it = rand_push((ph == 5) ? 3 : 15);
        if ($urandom_range(99) < 45) it.op = 1'b1;
        send_item(it);
        n_items++;
      end
      wait_drain();
    end

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/kwm_pkg.sv
hdl/kwm_if.sv
hdl/kwm_ram.sv
hdl/kwm_ctrl.sv
hdl/kwm_dp.sv
hdl/k_way_merge_multikey_core.sv
verif/k_way_merge_multikey_core_tb.sv
